### src/asfr_pkg.sv
package asfr_pkg;

	// Longest frame that is still collected; one byte more is an overflow.
	localparam int FRAME_LIMIT = 60;

	// Field widths of the transactions.
	localparam int BYTE_W  = 8;
	localparam int EVENT_W = 3;
	localparam int IDX_W   = 6;

	// The byte counter must hold FRAME_LIMIT + 1 and the accepted lengths up to 38.
	localparam int CNT_BITS = $clog2(FRAME_LIMIT + 2);
	localparam int CNT_W    = (CNT_BITS > 6) ? CNT_BITS : 6;

	// Control characters.
	localparam logic [BYTE_W-1:0] CH_ENQ = 8'h05;
	localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
	localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;

	// Command characters.
	localparam logic [BYTE_W-1:0] CMD_POLL   = 8'h70; // 'p'
	localparam logic [BYTE_W-1:0] CMD_ID     = 8'h65; // 'e'
	localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h77; // 'w'
	localparam logic [BYTE_W-1:0] CMD_CONF   = 8'h63; // 'c'
	localparam logic [BYTE_W-1:0] CMD_SERIAL = 8'h53; // 'S'

	// Frame lengths that are accepted at ETX.
	localparam int LEN_SHORT = 6;
	localparam int LEN_CONF  = 7;
	localparam int LEN_MID   = 25;
	localparam int LEN_LONG  = 38;

	// Event codes reported with every result.
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE       = 3'd0,
		EV_ADDR_MATCH = 3'd1,
		EV_ACK_NOW    = 3'd2,
		EV_POLL       = 3'd3,
		EV_SERIAL_REQ = 3'd4,
		EV_ID_DONE    = 3'd5,
		EV_FRAME_DONE = 3'd6,
		EV_OVERFLOW   = 3'd7
	} event_t;

endpackage

### src/asfr_if.sv
// Received byte channel.
interface asfr_rx_if;
	logic                           valid;
	logic                           ready;
	logic [asfr_pkg::BYTE_W-1:0]    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Parse result channel.
interface asfr_res_if;
	logic                           valid;
	logic                           ready;
	logic [asfr_pkg::EVENT_W-1:0]   event_res;
	logic                           store_valid;
	logic [asfr_pkg::IDX_W-1:0]     store_index;
	logic [asfr_pkg::BYTE_W-1:0]    store_byte;
	logic [asfr_pkg::IDX_W-1:0]     frame_length;
	logic                           serial_frame;

	modport source (output valid, output event_res, output store_valid, output store_index,
		output store_byte, output frame_length, output serial_frame, input ready);
	modport sink   (input valid, input event_res, input store_valid, input store_index,
		input store_byte, input frame_length, input serial_frame, output ready);
endinterface

### src/addressed_serial_frame_receiver.sv
// A byte accepted into the input register passes through the parser into the result register, which gives its result.
// Throughput: one byte per cycle while results are taken; the parser stalls while a result waits unready.
// A waiting result register and the input register decouple the two channels.
// Reset (arst_n low, asynchronous): parser idle waiting for ENQ, counters and flags cleared,
// board_address zero, both pipeline registers empty.
module addressed_serial_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [asfr_pkg::BYTE_W-1:0]   wr_data,
	asfr_rx_if.sink                       rx_chan,
	asfr_res_if.source                    result_chan
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ADDR = 3'd1,
		PH_CMD  = 3'd2,
		PH_HOLD = 3'd3,
		PH_STX  = 3'd4,
		PH_SAVE = 3'd5,
		PH_ID   = 3'd7
	} phase_t;

	localparam int CNT_W = asfr_pkg::CNT_W;
	localparam int IDX_W = asfr_pkg::IDX_W;

	// Configuration register.
	logic [asfr_pkg::BYTE_W-1:0] board_address_q;

	// Input register.
	logic                        valid_s1;
	logic [asfr_pkg::BYTE_W-1:0] byte_s1;

	// Parser state.
	phase_t                      phase_q;
	logic [CNT_W-1:0]            count_q;
	logic                        serial_pending_q;
	logic [asfr_pkg::BYTE_W-1:0] second_byte_q;

	// Result register.
	logic                        res_valid_q;
	asfr_pkg::event_t            event_q;
	logic                        store_valid_q;
	logic [IDX_W-1:0]            store_index_q;
	logic [asfr_pkg::BYTE_W-1:0] store_byte_q;
	logic [IDX_W-1:0]            frame_length_q;
	logic                        serial_frame_q;

	// Next values from the parser.
	phase_t                      phase_n;
	logic [CNT_W-1:0]            count_n;
	logic [CNT_W-1:0]            count_inc;
	logic                        serial_pending_n;
	logic [asfr_pkg::BYTE_W-1:0] second_byte_n;
	asfr_pkg::event_t            event_n;
	logic                        store_valid_n;
	logic [IDX_W-1:0]            store_index_n;
	logic [IDX_W-1:0]            frame_length_n;
	logic                        serial_frame_n;
	logic                        accept_n;

	logic advance;

	// The input register moves on whenever the result register is free or being emptied.
	assign advance       = !res_valid_q || result_chan.ready;
	assign rx_chan.ready = !valid_s1 || advance;

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_address_q <= '0;
		end else if (wr_en) begin
			board_address_q <= wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (rx_chan.ready) begin
			valid_s1 <= rx_chan.valid;
			if (rx_chan.valid) begin
				byte_s1 <= rx_chan.rx_byte;
			end
		end
	end

	// Protocol parser: one byte from the input register per step.
	always_comb begin
		phase_n          = phase_q;
		count_n          = count_q;
		count_inc        = count_q + CNT_W'(1);
		serial_pending_n = serial_pending_q;
		second_byte_n    = second_byte_q;
		event_n          = asfr_pkg::EV_NONE;
		store_valid_n    = 1'b0;
		store_index_n    = '0;
		frame_length_n   = '0;
		serial_frame_n   = 1'b0;
		accept_n         = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				count_n = '0;
				if (byte_s1 == asfr_pkg::CH_ENQ) begin
					phase_n = PH_ADDR;
				end
			end
			PH_ADDR: begin
				if (byte_s1 == board_address_q) begin
					phase_n = PH_CMD;
					event_n = asfr_pkg::EV_ADDR_MATCH;
				end else begin
					phase_n = PH_IDLE;
				end
			end
			PH_CMD: begin
				case (byte_s1)
					asfr_pkg::CMD_POLL: begin
						phase_n = PH_HOLD;
						count_n = '0;
						event_n = asfr_pkg::EV_POLL;
					end
					asfr_pkg::CMD_ID: begin
						phase_n = PH_ID;
						count_n = '0;
					end
					asfr_pkg::CMD_WRITE, asfr_pkg::CMD_CONF: begin
						phase_n = PH_STX;
						count_n = '0;
						event_n = asfr_pkg::EV_ACK_NOW;
					end
					asfr_pkg::CMD_SERIAL: begin
						phase_n          = PH_STX;
						serial_pending_n = 1'b1;
						event_n          = asfr_pkg::EV_SERIAL_REQ;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
			PH_STX: begin
				if (byte_s1 == asfr_pkg::CH_STX) begin
					store_valid_n = 1'b1;
					count_n       = CNT_W'(1);
					phase_n       = PH_SAVE;
				end else if (byte_s1 == asfr_pkg::CH_ENQ) begin
					phase_n = PH_ADDR;
					count_n = '0;
				end else begin
					phase_n = PH_IDLE;
				end
			end
			PH_ID, PH_SAVE: begin
				store_valid_n = 1'b1;
				store_index_n = count_q[IDX_W-1:0];
				if (count_q == CNT_W'(1)) begin
					second_byte_n = byte_s1;
				end
				count_n = count_inc;
				if (count_inc > CNT_W'(asfr_pkg::FRAME_LIMIT)) begin
					event_n = asfr_pkg::EV_OVERFLOW;
					phase_n = PH_IDLE;
				end else if (byte_s1 == asfr_pkg::CH_ETX) begin
					if (phase_q == PH_ID) begin
						event_n        = asfr_pkg::EV_ID_DONE;
						frame_length_n = count_inc[IDX_W-1:0];
						phase_n        = PH_IDLE;
					end else begin
						// A pending serial request accepts any length.
						if (serial_pending_q) begin
							serial_pending_n = 1'b0;
							serial_frame_n   = 1'b1;
							accept_n         = 1'b1;
							phase_n          = PH_HOLD;
						end
						if (count_inc == CNT_W'(asfr_pkg::LEN_SHORT)) begin
							accept_n = 1'b1;
							phase_n  = PH_IDLE;
							count_n  = '0;
						end else if ((count_inc == CNT_W'(asfr_pkg::LEN_CONF)
								&& second_byte_q == asfr_pkg::CMD_CONF)
								|| count_inc == CNT_W'(asfr_pkg::LEN_MID)
								|| count_inc >= CNT_W'(asfr_pkg::LEN_LONG)) begin
							accept_n = 1'b1;
							phase_n  = PH_HOLD;
						end
						if (accept_n) begin
							event_n        = asfr_pkg::EV_FRAME_DONE;
							frame_length_n = count_inc[IDX_W-1:0];
						end
					end
				end else if (byte_s1 == asfr_pkg::CH_ENQ) begin
					phase_n = PH_ADDR;
					count_n = '0;
				end
			end
			default: begin
				// Hold after a poll or after an accepted frame that is not of the short length: the byte is dropped.
				phase_n = PH_IDLE;
			end
		endcase
	end

	// Parser state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			count_q          <= '0;
			serial_pending_q <= 1'b0;
			second_byte_q    <= '0;
			res_valid_q      <= 1'b0;
			event_q          <= asfr_pkg::EV_NONE;
			store_valid_q    <= 1'b0;
			store_index_q    <= '0;
			store_byte_q     <= '0;
			frame_length_q   <= '0;
			serial_frame_q   <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q          <= phase_n;
				count_q          <= count_n;
				serial_pending_q <= serial_pending_n;
				second_byte_q    <= second_byte_n;
				event_q          <= event_n;
				store_valid_q    <= store_valid_n;
				store_index_q    <= store_index_n;
				store_byte_q     <= store_valid_n ? byte_s1 : '0;
				frame_length_q   <= frame_length_n;
				serial_frame_q   <= serial_frame_n;
			end
		end
	end

	// Result channel.
	assign result_chan.valid        = res_valid_q;
	assign result_chan.event_res    = event_q;
	assign result_chan.store_valid  = store_valid_q;
	assign result_chan.store_index  = store_index_q;
	assign result_chan.store_byte   = store_byte_q;
	assign result_chan.frame_length = frame_length_q;
	assign result_chan.serial_frame = serial_frame_q;

`ifndef SYNTHESIS
	// A completed frame or ID always ends on a stored ETX.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (event_q == asfr_pkg::EV_FRAME_DONE || event_q == asfr_pkg::EV_ID_DONE)
		|-> store_valid_q && store_byte_q == asfr_pkg::CH_ETX)
		else $error("frame end reported without a stored ETX");

	// The serial flag is only given with a completed frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && serial_frame_q |-> event_q == asfr_pkg::EV_FRAME_DONE)
		else $error("serial flag outside a frame completion");

	// While collecting, the count stays within the frame limit; a payload frame
	// always holds its STX, while an ID frame starts from zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SAVE || phase_q == PH_ID)
		|-> count_q <= CNT_W'(asfr_pkg::FRAME_LIMIT)
			&& (phase_q == PH_ID || count_q >= CNT_W'(1)))
		else $error("byte count out of range while collecting");

	// An accepted byte always lands in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_chan.valid && rx_chan.ready |=> valid_s1)
		else $error("accepted byte lost at the input register");
`endif

endmodule
